FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define REPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Next-cycle implication.
`define REPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/repf_pkg.sv
package repf_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int HIST_DEPTH = 2 * MAX_WIDTH + 3;
  localparam int ADDR_W     = $clog2(HIST_DEPTH);
  localparam int POS_W      = $clog2(MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT);
  localparam int PEND_W     = $clog2(MAX_WIDTH + 3);
  localparam int DIM_W      = 12;
  localparam int LIM_W      = 16;
  localparam int SUM_W      = 20;
  localparam int PROD_W     = 2 * SUM_W;
  localparam int M16_W      = 17;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = 1;

  localparam logic       OP_DRAIN   = 1'b1;
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_LIMIT  = 2'd2;

  typedef enum logic [2:0] {
    RULE_BORDER = 3'd0,
    RULE_EQUAL  = 3'd1,
    RULE_TAKE_A = 3'd2,
    RULE_TAKE_B = 3'd3,
    RULE_BLEND  = 3'd4
  } rule_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;   // effective, 1..MAX_WIDTH
    logic [DIM_W-1:0] height;  // effective, 1..MAX_HEIGHT
    logic [LIM_W-1:0] limit;
  } cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] center;
    logic              interior;
    logic              last;
  } job_t;

  typedef struct packed {
    logic busy;
  } back_stat_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [15:0]       data;   // {b, a}
  } hist_wr_t;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] addr;
  } hist_rd_t;

endpackage

FILE: src/repf_hist.sv
module repf_hist (
  input  logic              clk,
  input  repf_pkg::hist_wr_t wr,
  input  repf_pkg::hist_rd_t rd,
  output logic [15:0]       rd_data
);
  import repf_pkg::*;

  logic [15:0] mem [HIST_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.re) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

FILE: src/repf_queue.sv
module repf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  repf_pkg::job_t push_job,
  input  logic           pop,
  output repf_pkg::job_t pop_job,
  output logic           empty
);
  import repf_pkg::*;

  job_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign empty   = (count_r == '0);
  assign pop_job = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

FILE: src/repf_front.sv
module repf_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  repf_pkg::cfg_t       cfg,
  input  logic                 clr,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic                 in_tuser,
  input  logic [15:0]          in_tdata,
  input  repf_pkg::back_stat_t bstat,
  input  logic                 q_empty,
  output logic                 push,
  output repf_pkg::job_t       job,
  output repf_pkg::hist_wr_t   wr
);
  import repf_pkg::*;

  logic [ADDR_W-1:0]   wp_r, wp_inc, cur_wp;
  logic [PEND_W-1:0]   pending_r, pend_inc, cur_pend, pending_nxt;
  logic [POS_W-1:0]    orow_r, ocol_r;
  logic                accept, is_drain, emit;
  logic signed [ADDR_W+1:0] diff, diff_adj;
  logic [DIM_W:0]      col_inc, row_inc;

  // history writes must not overtake window reads of the job in flight
  assign in_tready = q_empty && !bstat.busy;
  assign accept    = in_tvalid && in_tready;
  assign is_drain  = (in_tuser == OP_DRAIN);

  always_comb begin
    wp_inc   = (wp_r == ADDR_W'(HIST_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    pend_inc = pending_r + 1'b1;
    cur_wp   = is_drain ? wp_r : wp_inc;
    cur_pend = is_drain ? pending_r : pend_inc;
    if (is_drain) begin
      emit = (pending_r != '0);
    end else begin
      emit = ({1'b0, pend_inc} >= ({1'b0, cfg.width} + (DIM_W+1)'(2)));
    end
    diff     = $signed({2'b00, cur_wp}) - $signed({(ADDR_W + 2 - PEND_W)'(0), cur_pend});
    diff_adj = diff + (ADDR_W+2)'(HIST_DEPTH);
    job.center   = (diff < 0) ? diff_adj[ADDR_W-1:0] : diff[ADDR_W-1:0];
    job.interior = (orow_r > POS_W'(1)) && (ocol_r > POS_W'(1)) &&
                   (({2'b00, orow_r} + (DIM_W+1)'(2)) < {1'b0, cfg.height}) &&
                   (({2'b00, ocol_r} + (DIM_W+1)'(2)) < {1'b0, cfg.width});
    job.last     = ({1'b0, orow_r} == cfg.height - 1'b1) &&
                   ({1'b0, ocol_r} == cfg.width - 1'b1);
    push = accept && emit;
    if (is_drain) begin
      pending_nxt = emit ? pending_r - 1'b1 : pending_r;
    end else begin
      pending_nxt = emit ? pending_r : pend_inc;
    end
    col_inc = {2'b00, ocol_r} + 1'b1;
    row_inc = {2'b00, orow_r} + 1'b1;
    wr.we   = accept && !is_drain;
    wr.addr = wp_r;
    wr.data = in_tdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      pending_r <= '0;
      orow_r    <= '0;
      ocol_r    <= '0;
    end else if (clr) begin
      pending_r <= '0;
      orow_r    <= '0;
      ocol_r    <= '0;
    end else if (accept) begin
      if (!is_drain) wp_r <= wp_inc;
      pending_r <= pending_nxt;
      if (emit) begin
        if (col_inc >= {1'b0, cfg.width}) begin
          ocol_r <= '0;
          orow_r <= (row_inc >= {1'b0, cfg.height}) ? '0 : row_inc[POS_W-1:0];
        end else begin
          ocol_r <= col_inc[POS_W-1:0];
        end
      end
    end
  end

endmodule

FILE: src/repf_back.sv
`include "assert_macros.svh"

module repf_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  repf_pkg::cfg_t       cfg,
  input  logic                 q_empty,
  input  repf_pkg::job_t       q_job,
  output logic                 q_pop,
  output repf_pkg::back_stat_t bstat,
  output repf_pkg::hist_rd_t   rd,
  input  logic [15:0]          rd_data,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,   // [7:0] fused_pixel, [10:8] rule_used, rest 0
  output logic                 out_tlast    // frame_end
);
  import repf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD, ST_MUL, ST_DIV1, ST_DEC, ST_MUL2, ST_DIV2, ST_RES
  } state_t;

  state_t            state_r;
  job_t              job_r;
  logic [3:0]        k_r;
  logic [4:0]        cnt_r;
  logic [SUM_W-1:0]  saa_r, sbb_r, sab_r;
  logic [7:0]        ca_r, cb_r;
  logic [PROD_W-1:0] den_r, sab2_r;
  logic [PROD_W:0]   rem_r, cand;
  logic [M16_W-1:0]  m16_r, dm;
  logic [24:0]       t_r;
  logic [25:0]       rem2_r, sh;
  logic [17:0]       qd;
  logic [7:0]        sub_r, sub_nxt, mx, mn, va, vb;
  logic [7:0]        pix_r, res_pix, out_pix_r;
  rule_t             rule_r, res_rule, out_rule_r;
  logic              last_r, ge1, ge2, below, res_load;
  logic signed [ADDR_W+1:0] asum;
  logic [DIM_W:0]    rowoff;
  logic [8:0]        avg;

  assign q_pop      = (state_r == ST_IDLE) && !q_empty;
  assign bstat.busy = (state_r != ST_IDLE);
  // output register is free or being emptied this cycle
  assign res_load   = (state_r == ST_RES) && (!out_tvalid || out_tready);
  assign out_tdata  = {5'd0, out_rule_r, out_pix_r};
  assign out_tlast  = last_r;

  always_comb begin
    // window address: center + dr*width + dc, one ring wrap either side
    rowoff = {1'b0, cfg.width};
    asum   = $signed({2'b00, job_r.center});
    case (k_r)
      4'd0, 4'd1, 4'd2: asum = asum - $signed({{(ADDR_W+1-DIM_W){1'b0}}, rowoff});
      4'd6, 4'd7, 4'd8: asum = asum + $signed({{(ADDR_W+1-DIM_W){1'b0}}, rowoff});
      default:          asum = asum;
    endcase
    if (k_r inside {4'd0, 4'd3, 4'd6}) begin
      asum = asum - (ADDR_W+2)'(1);
    end else if (k_r inside {4'd2, 4'd5, 4'd8}) begin
      asum = asum + (ADDR_W+2)'(1);
    end
    if (asum < 0) begin
      asum = asum + (ADDR_W+2)'(HIST_DEPTH);
    end else if (asum >= (ADDR_W+2)'(HIST_DEPTH)) begin
      asum = asum - (ADDR_W+2)'(HIST_DEPTH);
    end
    rd.re   = (state_r == ST_RD) && (k_r < 4'd9);
    rd.addr = asum[ADDR_W-1:0];

    va = rd_data[7:0];
    vb = rd_data[15:8];

    cand = (cnt_r == '0) ? rem_r : {rem_r[PROD_W-1:0], 1'b0};
    ge1  = (cand >= {1'b0, den_r});

    mx    = (ca_r > cb_r) ? ca_r : cb_r;
    mn    = (ca_r > cb_r) ? cb_r : ca_r;
    avg   = {1'b0, ca_r} + {1'b0, cb_r};
    below = (den_r == '0) || (m16_r < {1'b0, cfg.limit});
    dm    = m16_r - {1'b0, cfg.limit};
    qd    = {(17'h10000 - {1'b0, cfg.limit}), 1'b0};

    sh      = 26'(qd) << cnt_r[2:0];
    ge2     = (rem2_r >= sh);
    sub_nxt = sub_r | (8'(ge2) << cnt_r[2:0]);

    res_pix  = avg[8:1];
    res_rule = RULE_EQUAL;
    if (saa_r > sbb_r) begin
      res_pix  = ca_r;
      res_rule = RULE_TAKE_A;
    end else if (saa_r < sbb_r) begin
      res_pix  = cb_r;
      res_rule = RULE_TAKE_B;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      out_tvalid <= 1'b0;
    end else begin
      if (res_load) begin
        out_tvalid <= 1'b1;
      end else if (out_tvalid && out_tready) begin
        out_tvalid <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            job_r   <= q_job;
            k_r     <= '0;
            saa_r   <= '0;
            sbb_r   <= '0;
            sab_r   <= '0;
            state_r <= ST_RD;
          end
        end
        ST_RD: begin
          k_r <= k_r + 1'b1;
          if (k_r != 4'd0) begin
            saa_r <= saa_r + SUM_W'(va * va);
            sbb_r <= sbb_r + SUM_W'(vb * vb);
            sab_r <= sab_r + SUM_W'(va * vb);
          end
          if (k_r == 4'd5) begin
            ca_r <= va;
            cb_r <= vb;
          end
          if (k_r == 4'd9) begin
            if (job_r.interior) begin
              state_r <= ST_MUL;
            end else begin
              pix_r   <= 8'((({1'b0, ca_r} + {1'b0, cb_r}) >> 1));
              rule_r  <= RULE_BORDER;
              state_r <= ST_RES;
            end
          end
        end
        ST_MUL: begin
          den_r   <= saa_r * sbb_r;
          sab2_r  <= sab_r * sab_r;
          state_r <= ST_DIV1;
          cnt_r   <= '0;
          m16_r   <= '0;
          rem_r   <= '0;
        end
        ST_DIV1: begin
          if (cnt_r == '0) begin
            rem_r <= ({1'b0, sab2_r} >= {1'b0, den_r}) ? {1'b0, sab2_r - den_r}
                                                      : {1'b0, sab2_r};
            m16_r <= M16_W'({1'b0, sab2_r} >= {1'b0, den_r});
          end else begin
            rem_r <= ge1 ? cand - {1'b0, den_r} : cand;
            m16_r <= {m16_r[M16_W-2:0], ge1};
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 5'd16) state_r <= ST_DEC;
        end
        ST_DEC: begin
          if (below) begin
            pix_r   <= res_pix;
            rule_r  <= res_rule;
            state_r <= ST_RES;
          end else begin
            t_r     <= 25'((mx - mn) * dm);
            state_r <= ST_MUL2;
          end
        end
        ST_MUL2: begin
          rem2_r  <= {1'b0, t_r} + 26'(qd) - 26'd1;
          sub_r   <= '0;
          cnt_r   <= 5'd7;
          state_r <= ST_DIV2;
        end
        ST_DIV2: begin
          if (ge2) rem2_r <= rem2_r - sh;
          sub_r <= sub_nxt;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            pix_r   <= mx - sub_nxt;
            rule_r  <= RULE_BLEND;
            state_r <= ST_RES;
          end
        end
        ST_RES: begin
          // result moves to the output register only once it is free
          if (res_load) begin
            out_pix_r  <= pix_r;
            out_rule_r <= rule_r;
            last_r     <= job_r.last;
            state_r    <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `REPF_ASSERT(a_pop_idle, q_pop |-> !bstat.busy, "job popped while busy")
  `REPF_ASSERT_NEXT(a_res_load, (state_r == ST_RES) && (!out_tvalid || out_tready), out_tvalid && (state_r == ST_IDLE), "result not loaded")
  `REPF_ASSERT(a_blend_pix, (state_r == ST_DIV2) && (cnt_r == '0) |-> (sub_nxt <= mx), "blend underflow")

endmodule

FILE: src/region_energy_pixel_fusion.sv
// Processing: a border pixel takes only the window reads in the back unit; an interior
// pixel also takes a 17-step match-degree divider and, for a blend, an 8-step blend divider.
// Flow control: an emitting request holds off input until its result is loaded into the
// output register, which waits while out_tready is low and that register is full; a
// request that emits nothing holds off no input itself.
// Reset: rst_n synchronous, active low; 640x480, limit 40501, history undefined.
`include "assert_macros.svh"

module region_energy_pixel_fusion (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] pixel_a, [15:8] pixel_b
  input  logic        in_tuser,   // operation: 0 pixel pair, 1 drain
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] fused_pixel, [10:8] rule_used, [15:11] zero
  output logic        out_tlast,  // frame_end
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import repf_pkg::*;

  logic [DIM_W-1:0] width_r, height_r;
  logic [LIM_W-1:0] limit_r;
  cfg_t             cfg;
  logic             cfg_wr, clr;
  back_stat_t       bstat;
  job_t             push_job, pop_job;
  logic             push, pop, q_empty;
  hist_wr_t         wr;
  hist_rd_t         rd;
  logic [15:0]      rd_data;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  // size writes restart the raster position and drop pending pixels
  assign clr       = cfg_wr && ((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT));

  always_comb begin
    // clamp sizes: zero acts as one, oversize as the maximum
    if (width_r == '0)                          cfg.width = DIM_W'(1);
    else if (width_r > DIM_W'(MAX_WIDTH))       cfg.width = DIM_W'(MAX_WIDTH);
    else                                        cfg.width = width_r;
    if (height_r == '0)                         cfg.height = DIM_W'(1);
    else if (height_r > DIM_W'(MAX_HEIGHT))     cfg.height = DIM_W'(MAX_HEIGHT);
    else                                        cfg.height = height_r;
    cfg.limit = limit_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(640);
      height_r <= DIM_W'(480);
      limit_r  <= LIM_W'(40501);
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data[DIM_W-1:0];
        REG_HEIGHT: height_r <= cfg_data[DIM_W-1:0];
        REG_LIMIT:  limit_r  <= cfg_data;
        default:    ;  // index beyond the register list
      endcase
    end
  end

  // front: takes requests, writes history, tracks raster and decides what to emit
  repf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .clr       (clr),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .bstat     (bstat),
    .q_empty   (q_empty),
    .push      (push),
    .job       (push_job),
    .wr        (wr)
  );

  // job queue between front and back
  repf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  // pixel-pair history ring
  repf_hist u_hist (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  // back: window sums, match degree, rule selection, output register
  repf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_empty    (q_empty),
    .q_job      (pop_job),
    .q_pop      (pop),
    .bstat      (bstat),
    .rd         (rd),
    .rd_data    (rd_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  `REPF_ASSERT(a_no_write_busy, bstat.busy |-> !wr.we, "history written during window read")
  `REPF_ASSERT(a_push_empty, push |-> q_empty, "job stacked behind another")
  `REPF_ASSERT(a_busy_from_job, $rose(bstat.busy) |-> $past(!q_empty), "back started with no job")

endmodule

FILE: test/region_energy_pixel_fusion_tb.sv
`timescale 1ns / 100ps

module region_energy_pixel_fusion_tb;
  import repf_pkg::*;

  typedef struct {
    logic       drain;
    logic [7:0] pix_a;
    logic [7:0] pix_b;
  } pair_req_t;

  typedef struct {
    logic [7:0] pixel;
    rule_t      rule;
    logic       last;
  } fused_exp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // pending stimulus and expected fused pixels
  pair_req_t  pair_queue[$];
  fused_exp_t fused_queue[$];
  int         error_count = 0;

  // idling knobs, percent per cycle
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic hold_on = 1'b0;
  logic hold_go = 1'b0;

  // shadow of the block: config, history ring and raster positions
  logic [11:0] width_reg;
  logic [11:0] height_reg;
  logic [15:0] limit_reg;
  logic [7:0]  ring_a[HIST_DEPTH];
  logic [7:0]  ring_b[HIST_DEPTH];
  int          ring_wr;
  int          in_row, in_col, out_row, out_col, pend;

  region_energy_pixel_fusion DUT (.*);

  always #6 clk = ~clk;

  function automatic int eff_dim(logic [11:0] raw, int max_dim);
    if (raw == 0) return 1;
    if (raw > max_dim) return max_dim;
    return raw;
  endfunction

  // ring slot of the request k places back from the write pointer
  function automatic int ring_slot(int k);
    return (ring_wr + 2 * HIST_DEPTH - k) % HIST_DEPTH;
  endfunction

  function automatic void clear_raster();
    in_row = 0; in_col = 0; out_row = 0; out_col = 0; pend = 0;
  endfunction

  // fuse the oldest position still waiting in the ring
  function automatic void fuse_oldest_position();
    int w, h, ctr, s, off, mx, mn;
    longint unsigned saa, sbb, sab, den, m16, t, q;
    logic [7:0] a, b;
    fused_exp_t e;
    w = eff_dim(width_reg, MAX_WIDTH);
    h = eff_dim(height_reg, MAX_HEIGHT);
    ctr = ring_slot(pend);
    a = ring_a[ctr];
    b = ring_b[ctr];
    saa = 0; sbb = 0; sab = 0;
    if (out_row > 1 && out_row + 2 < h && out_col > 1 && out_col + 2 < w) begin
      for (int dr = -1; dr <= 1; dr++) begin
        for (int dc = -1; dc <= 1; dc++) begin
          off = dr * w + dc;
          s = ring_slot(pend - off);
          saa += ring_a[s] * ring_a[s];
          sbb += ring_b[s] * ring_b[s];
          sab += ring_a[s] * ring_b[s];
        end
      end
      den = saa * sbb;
      m16 = (den == 0) ? 0 : (sab * sab * 65536) / den;
      if (den == 0 || m16 < limit_reg) begin
        // weak match: pick by energy
        if (saa == sbb) begin
          e.pixel = 8'((9'(a) + 9'(b)) >> 1); e.rule = RULE_EQUAL;
        end else if (saa > sbb) begin
          e.pixel = a; e.rule = RULE_TAKE_A;
        end else begin
          e.pixel = b; e.rule = RULE_TAKE_B;
        end
      end else begin
        // blend toward the larger pixel, rounded down
        mx = (a > b) ? a : b;
        mn = (a > b) ? b : a;
        t = (mx - mn) * (m16 - limit_reg);
        q = 2 * (65536 - limit_reg);
        e.pixel = 8'(mx - ((t + q - 1) / q));
        e.rule = RULE_BLEND;
      end
    end else begin
      e.pixel = 8'((9'(a) + 9'(b)) >> 1);
      e.rule = RULE_BORDER;
    end
    e.last = (out_row == h - 1 && out_col == w - 1);
    fused_queue.push_back(e);
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
      if (out_row >= h) out_row = 0;
    end
    pend--;
  endfunction

  function automatic void fusion_predict(pair_req_t r);
    int w, h;
    w = eff_dim(width_reg, MAX_WIDTH);
    h = eff_dim(height_reg, MAX_HEIGHT);
    if (r.drain == OP_DRAIN) begin
      if (pend != 0) fuse_oldest_position();
    end else begin
      ring_a[ring_wr] = r.pix_a;
      ring_b[ring_wr] = r.pix_b;
      ring_wr = (ring_wr + 1) % HIST_DEPTH;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
        if (in_row >= h) in_row = 0;
      end
      pend++;
      if (pend >= w + 2) fuse_oldest_position();
    end
  endfunction

  task automatic flag_mismatch(string what);
    $display("[%0t] fusion check failed: %s", $realtime, what);
    error_count++;
  endtask

  // driver: a request moves when valid and ready meet at the edge
  always @(posedge clk) begin
    pair_req_t r;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        r.drain = in_tuser;
        r.pix_a = in_tdata[7:0];
        r.pix_b = in_tdata[15:8];
        fusion_predict(r);
      end
      if (!in_tvalid || in_tready) begin
        if (pair_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          r = pair_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= r.drain;
          in_tdata  <= {r.pix_b, r.pix_a};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    fused_exp_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (fused_queue.size() == 0) begin
          flag_mismatch($sformatf("unexpected result %h", out_tdata));
        end else begin
          e = fused_queue.pop_front();
          if (out_tdata[7:0] !== e.pixel)
            flag_mismatch($sformatf("pixel %0d, want %0d", out_tdata[7:0], e.pixel));
          if (out_tdata[10:8] !== e.rule)
            flag_mismatch($sformatf("rule %0d, want %0d", out_tdata[10:8], e.rule));
          if (out_tdata[15:11] !== 5'd0)
            flag_mismatch($sformatf("pad bits %b", out_tdata[15:11]));
          if (out_tlast !== e.last)
            flag_mismatch($sformatf("frame end %b, want %b", out_tlast, e.last));
        end
      end
      out_tready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (600) @(posedge clk);
    hold_on <= 1'b0;
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_WIDTH: begin
        width_reg = val[11:0];
        clear_raster();
      end
      REG_HEIGHT: begin
        height_reg = val[11:0];
        clear_raster();
      end
      REG_LIMIT: limit_reg = val;
      default: ;
    endcase
  endtask

  // quiet point: stimulus gone, results in, back unit settled
  task automatic wait_idle();
    while (pair_queue.size() != 0 || in_tvalid || fused_queue.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic push_pair(logic drain, logic [7:0] a, logic [7:0] b);
    pair_req_t r;
    r.drain = drain;
    r.pix_a = a;
    r.pix_b = b;
    pair_queue.push_back(r);
  endtask

  // one frame of pixel pairs; the style steers which rule fires
  task automatic push_frame(int w, int h, int style, int drain_pct);
    logic [7:0] a, b;
    int nz, av;
    for (int i = 0; i < w * h; i++) begin
      a = 8'($urandom_range(255));
      nz = $urandom_range(16) - 8;
      case (style)
        0: b = 8'($urandom_range(255));
        1: b = a;
        2: b = a >> 1;
        3: begin a = 8'd0; b = 8'($urandom_range(255)); end
        4: begin a = 8'd0; b = 8'd0; end
        5: begin
          av = int'(a) + nz;
          b = (av < 0) ? 8'd0 : (av > 255) ? 8'd255 : 8'(av);
        end
        6: b = ~a;
        default: begin a = 8'($urandom_range(255)); b = 8'd0; end
      endcase
      push_pair(1'b0, a, b);
      // stray drains mid-frame
      if ($urandom_range(99) < drain_pct)
        push_pair(OP_DRAIN, 8'($urandom_range(255)), 8'($urandom_range(255)));
    end
  endtask

  initial begin
    int w, h, n_sent, phase;
    width_reg = 640;
    height_reg = 480;
    limit_reg = 40501;
    ring_wr = 0;
    clear_raster();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Fill the whole history once at the widest size (4095 clamps to max,
    // height 0 acts as one row) so no window ever reads stale-unknown data.
    write_reg(REG_WIDTH, 16'h0fff);
    write_reg(REG_HEIGHT, 16'h0000);
    write_reg(REG_LIMIT, 16'hffff);
    for (int i = 0; i < HIST_DEPTH; i++)
      push_pair(1'b0, 8'($urandom_range(255)), 8'($urandom_range(255)));
    for (int i = 0; i < 40; i++) push_pair(OP_DRAIN, 8'hff, 8'h00);
    wait_idle();

    // Directed: width 0 acts as one, a one-wide frame is all border,
    // drain with nothing pending gives no result.
    write_reg(REG_WIDTH, 16'd0);
    write_reg(REG_HEIGHT, 16'd3);
    push_pair(OP_DRAIN, 8'h00, 8'hff);
    push_pair(1'b0, 8'hff, 8'hff);
    push_pair(1'b0, 8'h00, 8'h00);
    push_pair(1'b0, 8'hff, 8'h00);
    push_pair(1'b0, 8'h00, 8'hff);
    push_pair(OP_DRAIN, 8'h00, 8'h00);
    push_pair(OP_DRAIN, 8'h00, 8'h00);
    push_pair(OP_DRAIN, 8'h00, 8'h00);
    wait_idle();
    write_reg(REG_WIDTH, 16'd5);
    write_reg(REG_HEIGHT, 16'd5);
    write_reg(REG_LIMIT, 16'd0);
    push_frame(5, 5, 1, 0);
    for (int i = 0; i < 7; i++) push_pair(OP_DRAIN, 8'h00, 8'h00);
    wait_idle();

    // Random phases, rotating the idling pattern each time.
    n_sent = 0;
    phase = 0;
    while (n_sent < 1600) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      w = ($urandom_range(9) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 12);
      h = ($urandom_range(9) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 9);
      write_reg(REG_WIDTH, 16'(w));
      write_reg(REG_HEIGHT, 16'(h));
      case ($urandom_range(5))
        0: write_reg(REG_LIMIT, 16'd0);
        1: write_reg(REG_LIMIT, 16'hffff);
        2: write_reg(REG_LIMIT, 16'd40501);
        default: write_reg(REG_LIMIT, 16'($urandom_range(65535)));
      endcase
      repeat ($urandom_range(1, 2)) push_frame(w, h, $urandom_range(7), 3);
      for (int i = 0; i < w + 2; i++)
        push_pair(OP_DRAIN, 8'($urandom_range(255)), 8'($urandom_range(255)));
      n_sent += pair_queue.size();
      if (phase == 1) hold_go = 1'b1;
      wait_idle();
      phase++;
    end

    if (error_count == 0)
      $display("region_energy_pixel_fusion: match");
    else
      $display("region_energy_pixel_fusion: mismatch");
    $finish;
  end

  initial begin
    #20ms;
    $display("region_energy_pixel_fusion: mismatch");
    $finish;
  end

endmodule
